// File: rtl/bpc_pkg.sv
package bpc_pkg;

   localparam int unsigned WORD_W = 32;

   typedef logic [WORD_W-1:0] word_type;

   // fixed terms of the compensation formula
   localparam word_type B6_OFFSET   = 32'd4000;
   localparam word_type X3_OFFSET   = 32'd32768;
   localparam word_type B7_SCALE    = 32'd50000;
   localparam word_type FIT_SQUARE  = 32'd3038;
   localparam word_type FIT_LINEAR  = 32'hFFFF_E343;   // -7357
   localparam word_type FIT_OFFSET  = 32'd3791;

endpackage

// File: rtl/bpc_div.sv
module bpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bpc_pkg::word_type    dividend,
   input  bpc_pkg::word_type    divisor,
   output logic                 done,
   output bpc_pkg::word_type    quotient
);

   localparam int unsigned CNT_W = $clog2(bpc_pkg::WORD_W + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [bpc_pkg::WORD_W:0] rem_ff, rem_in;
   bpc_pkg::word_type       quo_ff, quo_in;
   bpc_pkg::word_type       dvs_ff, dvs_in;
   logic [bpc_pkg::WORD_W:0] trial;
   logic [bpc_pkg::WORD_W:0] shifted;

   // one restoring step a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff[bpc_pkg::WORD_W-1:0], quo_ff[bpc_pkg::WORD_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(bpc_pkg::WORD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[bpc_pkg::WORD_W]) begin
            rem_in = trial;
            quo_in = {quo_ff[bpc_pkg::WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[bpc_pkg::WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/barometric_pressure_compensation_core.sv
// a temperature transfer only stores its reading and gives no result; a pressure
// transfer runs two 32-step divisions on the shared divider plus eleven multiplies and
// ends early with a fault result on a zero divisor; a result waits while rsp_ready is low.
// req_ready is high only when the sequencer idles, so one pressure transfer runs at a time.
// reset: synchronous, active high; calibration, oversampling and stored
// temperature clear to zero, no result pending.
module barometric_pressure_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [18:0] req_raw_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pressure_pa,
   output logic        rsp_div_fault,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // register indexes
   localparam logic [1:0] REG_CAL_A = 2'd0;
   localparam logic [1:0] REG_CAL_B = 2'd1;
   localparam logic [1:0] REG_CAL_C = 2'd2;
   localparam logic [1:0] REG_OSS   = 2'd3;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_T1   = 4'd1;
   localparam logic [3:0] ST_D1   = 4'd2;
   localparam logic [3:0] ST_P1   = 4'd3;
   localparam logic [3:0] ST_P2   = 4'd4;
   localparam logic [3:0] ST_P3   = 4'd5;
   localparam logic [3:0] ST_P4   = 4'd6;
   localparam logic [3:0] ST_P5   = 4'd7;
   localparam logic [3:0] ST_P6   = 4'd8;
   localparam logic [3:0] ST_P7   = 4'd9;
   localparam logic [3:0] ST_D2   = 4'd10;
   localparam logic [3:0] ST_P8   = 4'd11;
   localparam logic [3:0] ST_P9   = 4'd12;
   localparam logic [3:0] ST_P10  = 4'd13;

   typedef bpc_pkg::word_type word_type;

   logic [3:0]  state_ff, state_in;
   logic [63:0] cal_a_ff, cal_a_in;
   logic [63:0] cal_b_ff, cal_b_in;
   logic [47:0] cal_c_ff, cal_c_in;
   logic [1:0]  oss_ff, oss_in;
   logic [15:0] ut_ff, ut_in;
   logic [18:0] up_ff, up_in;
   word_type    a_ff, a_in, b_ff, b_in;     // shared multiplier operands
   word_type    acc_ff, acc_in;             // running x1 / partial sums
   word_type    b6_ff, b6_in, sq_ff, sq_in, b3_ff, b3_in, b4_ff, b4_in, p_ff, p_in;
   logic        flag_ff, flag_in;           // quotient sign, or post-shift of p
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_p_ff, rsp_p_in;
   logic        rsp_fault_ff, rsp_fault_in;

   word_type    prod;
   logic        div_start, div_done;
   word_type    div_dividend, div_divisor, div_quotient;
   logic        out_free;

   // calibration fields
   word_type ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = 32'($signed(cal_a_ff[63:48]));
   assign ac2 = 32'($signed(cal_a_ff[47:32]));
   assign ac3 = 32'($signed(cal_a_ff[31:16]));
   assign ac4 = {16'd0, cal_a_ff[15:0]};
   assign ac5 = {16'd0, cal_b_ff[63:48]};
   assign ac6 = {16'd0, cal_b_ff[47:32]};
   assign b1  = 32'($signed(cal_b_ff[31:16]));
   assign b2  = 32'($signed(cal_b_ff[15:0]));
   assign mc  = 32'($signed(cal_c_ff[31:16]));
   assign md  = 32'($signed(cal_c_ff[15:0]));

   // the one shared multiplier, low word of the product
   assign prod = 32'(a_ff * b_ff);

   assign out_free = !rsp_valid_ff || rsp_ready;

   bpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      word_type x1, x2, x3, den, mc_sh, q, b7, pv;
      state_in     = state_ff;
      cal_a_in     = cal_a_ff;
      cal_b_in     = cal_b_ff;
      cal_c_in     = cal_c_ff;
      oss_in       = oss_ff;
      ut_in        = ut_ff;
      up_in        = up_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      b6_in        = b6_ff;
      sq_in        = sq_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      p_in         = p_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_p_in     = rsp_p_ff;
      rsp_fault_in = rsp_fault_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      x1    = $signed(prod) >>> 15;
      den   = x1 + md;
      mc_sh = mc << 11;
      q     = flag_ff ? (32'd0 - div_quotient) : div_quotient;
      x2    = '0;
      x3    = '0;
      b7    = prod;
      pv    = flag_ff ? (div_quotient << 1) : div_quotient;

      if (csr_we) begin
         unique case (csr_index)
            REG_CAL_A: cal_a_in = csr_wdata;
            REG_CAL_B: cal_b_in = csr_wdata;
            REG_CAL_C: cal_c_in = csr_wdata[47:0];
            REG_OSS:   oss_in   = csr_wdata[1:0];
            default:   ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_func) begin
                  ut_in = req_raw_value[15:0];
               end else begin
                  up_in    = req_raw_value;
                  a_in     = {16'd0, ut_ff} - ac6;
                  b_in     = ac5;
                  state_in = ST_T1;
               end
            end
         end
         ST_T1: begin
            // temperature term and start of the first division, or a fault result on a zero divisor
            acc_in = x1;
            if (den == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_p_in     = '0;
                  rsp_fault_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               div_start    = 1'b1;
               div_dividend = mc_sh[31] ? (32'd0 - mc_sh) : mc_sh;
               div_divisor  = den[31] ? (32'd0 - den) : den;
               flag_in      = mc_sh[31] ^ den[31];
               state_in     = ST_D1;
            end
         end
         ST_D1: begin
            if (div_done) begin
               x2       = acc_ff + q;                       // b5
               b6_in    = x2 - bpc_pkg::B6_OFFSET;
               a_in     = x2 - bpc_pkg::B6_OFFSET;
               b_in     = x2 - bpc_pkg::B6_OFFSET;
               state_in = ST_P1;
            end
         end
         ST_P1: begin
            sq_in    = $signed(prod) >>> 12;
            a_in     = b2;
            b_in     = $signed(prod) >>> 12;
            state_in = ST_P2;
         end
         ST_P2: begin
            acc_in   = $signed(prod) >>> 11;
            a_in     = ac2;
            b_in     = b6_ff;
            state_in = ST_P3;
         end
         ST_P3: begin
            x3       = acc_ff + word_type'($signed(prod) >>> 11);
            x2       = (((ac1 << 2) + x3) << oss_ff) + 32'd2;
            b3_in    = $signed(x2) >>> 2;
            a_in     = ac3;
            b_in     = b6_ff;
            state_in = ST_P4;
         end
         ST_P4: begin
            acc_in   = $signed(prod) >>> 13;
            a_in     = b1;
            b_in     = sq_ff;
            state_in = ST_P5;
         end
         ST_P5: begin
            x2       = acc_ff + word_type'($signed(prod) >>> 16) + 32'd2;
            x3       = $signed(x2) >>> 2;
            a_in     = ac4;
            b_in     = x3 + bpc_pkg::X3_OFFSET;
            state_in = ST_P6;
         end
         ST_P6: begin
            // b4, the divisor of the pressure step
            b4_in = prod >> 15;
            if ((prod >> 15) == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_p_in     = '0;
                  rsp_fault_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               a_in     = {13'd0, up_ff} - b3_ff;
               b_in     = bpc_pkg::B7_SCALE >> oss_ff;
               state_in = ST_P7;
            end
         end
         ST_P7: begin
            div_start    = 1'b1;
            div_dividend = b7[31] ? b7 : (b7 << 1);
            div_divisor  = b4_ff;
            flag_in      = b7[31];
            state_in     = ST_D2;
         end
         ST_D2: begin
            if (div_done) begin
               p_in     = pv;
               a_in     = $signed(pv) >>> 8;
               b_in     = $signed(pv) >>> 8;
               state_in = ST_P8;
            end
         end
         ST_P8: begin
            a_in     = prod;
            b_in     = bpc_pkg::FIT_SQUARE;
            state_in = ST_P9;
         end
         ST_P9: begin
            acc_in   = $signed(prod) >>> 16;
            a_in     = p_ff;
            b_in     = bpc_pkg::FIT_LINEAR;
            state_in = ST_P10;
         end
         ST_P10: begin
            if (out_free) begin
               x2           = acc_ff + word_type'($signed(prod) >>> 16) + bpc_pkg::FIT_OFFSET;
               rsp_valid_in = 1'b1;
               rsp_p_in     = p_ff + word_type'($signed(x2) >>> 4);
               rsp_fault_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cal_a_ff     <= '0;
         cal_b_ff     <= '0;
         cal_c_ff     <= '0;
         oss_ff       <= '0;
         ut_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cal_a_ff     <= cal_a_in;
         cal_b_ff     <= cal_b_in;
         cal_c_ff     <= cal_c_in;
         oss_ff       <= oss_in;
         ut_ff        <= ut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      up_ff        <= up_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      acc_ff       <= acc_in;
      b6_ff        <= b6_in;
      sq_ff        <= sq_in;
      b3_ff        <= b3_in;
      b4_ff        <= b4_in;
      p_ff         <= p_in;
      flag_ff      <= flag_in;
      rsp_p_ff     <= rsp_p_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pressure_pa = rsp_p_ff;
   assign rsp_div_fault   = rsp_fault_ff;

`ifndef NO_ASSERTIONS
   // the divider is only kicked off from the two launch states
   a_div_start_state: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == ST_T1 || state_ff == ST_P7))
      else $error("divider started outside a launch state");

   // a finished division is only ever seen by a waiting state
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_D1 || state_ff == ST_D2))
      else $error("division finished with no state waiting");

   // a fault result always carries zero pressure
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_fault) |-> (rsp_pressure_pa == '0))
      else $error("fault result with nonzero pressure");

   // the last step lands a result whenever the output is free
   a_final_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P10 && out_free) |=> rsp_valid)
      else $error("final step gave no result");
`endif

endmodule

// File: tb/bpc_tb_pkg.sv
`timescale 1ns / 1ps
package bpc_tb_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] REG_CAL_A   = 2'd0;
   localparam logic [1:0] REG_CAL_B   = 2'd1;
   localparam logic [1:0] REG_CAL_C   = 2'd2;
   localparam logic [1:0] REG_OSS     = 2'd3;

   // reading kinds
   localparam logic FUNC_TEMPERATURE = 1'b0;
   localparam logic FUNC_PRESSURE    = 1'b1;

endpackage

// File: tb/pressure_checker.sv
`timescale 1ns / 1ps
module pressure_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [18:0] req_raw_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pressure_pa,
   input  logic        rsp_div_fault,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] pressure;
      logic        fault;
   } pressure_result_type;

   pressure_result_type expected_pressures[$];

   logic [63:0] cal_a, cal_b;
   logic [47:0] cal_c;
   logic [1:0]  oss;
   logic [15:0] stored_temp;

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic pressure_result_type compensate(input logic [18:0] raw);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, up, den, sq, t;
      longint q;
      pressure_result_type r;
      up  = {13'd0, raw};
      ac1 = sx16(cal_a[63:48]);
      ac2 = sx16(cal_a[47:32]);
      ac3 = sx16(cal_a[31:16]);
      ac4 = {16'd0, cal_a[15:0]};
      ac5 = {16'd0, cal_b[63:48]};
      ac6 = {16'd0, cal_b[47:32]};
      b1  = sx16(cal_b[31:16]);
      b2  = sx16(cal_b[15:0]);
      mc  = sx16(cal_c[31:16]);
      md  = sx16(cal_c[15:0]);
      r.pressure = '0;
      r.fault    = 1'b1;
      // temperature term
      x1  = asr(({16'd0, stored_temp} - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) return r;
      q  = longint'($signed(mc)) * 2048 / longint'($signed(den));
      x2 = q[31:0];
      b5 = x1 + x2;
      // pressure term
      b6 = b5 - bpc_pkg::B6_OFFSET;
      sq = asr(b6 * b6, 12);
      x1 = asr(b2 * sq, 11);
      x2 = asr(ac2 * b6, 11);
      x3 = x1 + x2;
      t  = (ac1 * 32'd4 + x3) << oss;
      b3 = asr(t + 32'd2, 2);
      x1 = asr(ac3 * b6, 13);
      x2 = asr(b1 * sq, 16);
      x3 = asr(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + bpc_pkg::X3_OFFSET)) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * (bpc_pkg::B7_SCALE >> oss);
      if (b7 < 32'h8000_0000) begin
         t = b7 << 1;
         p = t / b4;
      end else begin
         t = b7 / b4;
         p = t << 1;
      end
      x1 = asr(p, 8) * asr(p, 8);
      x1 = asr(x1 * bpc_pkg::FIT_SQUARE, 16);
      x2 = asr(bpc_pkg::FIT_LINEAR * p, 16);
      r.pressure = p + asr(x1 + x2 + bpc_pkg::FIT_OFFSET, 4);
      r.fault    = 1'b0;
      return r;
   endfunction

   assign pending = expected_pressures.size();

   always @(posedge clock) begin
      pressure_result_type exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         cal_a       <= '0;
         cal_b       <= '0;
         cal_c       <= '0;
         oss         <= '0;
         stored_temp <= '0;
         fail_count  <= 0;
         expected_pressures.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bpc_tb_pkg::REG_CAL_A: cal_a <= csr_wdata;
               bpc_tb_pkg::REG_CAL_B: cal_b <= csr_wdata;
               bpc_tb_pkg::REG_CAL_C: cal_c <= csr_wdata[47:0];
               bpc_tb_pkg::REG_OSS:   oss   <= csr_wdata[1:0];
               default: ;
            endcase
         end
         // request transfer: store temperature or queue a predicted pressure
         if (req_valid && req_ready) begin
            if (req_func == bpc_tb_pkg::FUNC_TEMPERATURE)
               stored_temp <= req_raw_value[15:0];
            else
               expected_pressures.push_back(compensate(req_raw_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pressures.size() == 0) begin
               $error("unexpected result transfer, pressure_pa %0d", $signed(rsp_pressure_pa));
               errs += 1;
            end else begin
               exp_r = expected_pressures.pop_front();
               if (rsp_pressure_pa !== exp_r.pressure) begin
                  $error("pressure_pa expected %0d actual %0d",
                         $signed(exp_r.pressure), $signed(rsp_pressure_pa));
                  errs += 1;
               end
               if (rsp_div_fault !== exp_r.fault) begin
                  $error("div_fault expected %0d actual %0d", exp_r.fault, rsp_div_fault);
                  errs += 1;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [18:0] req_raw_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_pressure_pa;
   logic        rsp_div_fault;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;
   int          fail_count;
   int          pending;

   // no idling in the last part of the run
   logic        calm;
   int          rsp_stall;
   int          quiet_cycles;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_WAIT      = 120;

   // typical calibration words of a real part
   localparam logic [63:0] TYPICAL_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [63:0] TYPICAL_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
   localparam logic [47:0] TYPICAL_C = {-16'sd32768, -16'sd8711, 16'sd2868};

   barometric_pressure_compensation_core dut (.*);

   pressure_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= $urandom_range(1, 10) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic write_cal(input logic [63:0] a, input logic [63:0] b,
                            input logic [47:0] c, input logic [1:0] o);
      csr_we    <= 1'b1;
      csr_index <= bpc_tb_pkg::REG_CAL_A;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= bpc_tb_pkg::REG_CAL_B;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= bpc_tb_pkg::REG_CAL_C;
      csr_wdata <= {16'hFFFF, c};
      @(posedge clock);
      csr_index <= bpc_tb_pkg::REG_OSS;
      csr_wdata <= {$urandom, $urandom} & ~64'd3 | o;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // one request transfer, with a random gap in front unless calm
   task automatic send_reading(input logic func, input logic [18:0] raw);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_raw_value <= raw;
      do @(posedge clock); while (!req_ready);
   endtask

   // drain all results, then let a trailing temperature transfer settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic random_readings(input int count, input logic [1:0] o);
      int n;
      logic [18:0] raw;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) < 7) begin
            // well-formed pair: temperature then pressure
            raw = ($urandom_range(0, 4) == 0) ? 19'($urandom)
                                              : 19'($urandom_range(20000, 35000));
            send_reading(bpc_tb_pkg::FUNC_TEMPERATURE, raw);
            raw = ($urandom_range(0, 4) == 0) ? 19'($urandom)
                                              : 19'($urandom_range(15000, 90000) << o);
            send_reading(bpc_tb_pkg::FUNC_PRESSURE, raw);
            n += 2;
         end else begin
            send_reading(1'($urandom), 19'($urandom));
            n += 1;
         end
      end
   endtask

   initial begin
      logic [63:0] ra, rb;
      logic [47:0] rc;
      logic [1:0]  ro;
      calm          = 1'b0;
      rsp_stall     = 0;
      quiet_cycles  = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= bpc_tb_pkg::FUNC_TEMPERATURE;
      req_raw_value <= '0;
      rsp_ready     <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= bpc_tb_pkg::REG_CAL_A;
      csr_wdata     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: every pressure hits the zero temperature divisor
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'd0);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'h7FFFF);
      wait_idle();

      // typical part, pressure before any temperature uses the reset value
      write_cal(TYPICAL_A, TYPICAL_B, TYPICAL_C, 2'd0);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'd23843);
      send_reading(bpc_tb_pkg::FUNC_TEMPERATURE, 19'd27898);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'd23843);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'd0);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'h7FFFF);
      // only the low 16 bits of a temperature are kept
      send_reading(bpc_tb_pkg::FUNC_TEMPERATURE, 19'h7FFFF);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'h40000);
      send_reading(bpc_tb_pkg::FUNC_TEMPERATURE, 19'h70000);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'd30000);
      random_readings(130, 2'd0);
      wait_idle();

      write_cal(TYPICAL_A, TYPICAL_B, TYPICAL_C, 2'd3);
      send_reading(bpc_tb_pkg::FUNC_TEMPERATURE, 19'd27898);
      send_reading(bpc_tb_pkg::FUNC_PRESSURE, 19'h7FFFF);
      random_readings(130, 2'd3);
      wait_idle();

      // all ones: wrap-around everywhere
      write_cal('1, '1, '1, 2'd3);
      random_readings(120, 2'd3);
      wait_idle();

      // zero pressure divisor through ac4
      write_cal({TYPICAL_A[63:16], 16'd0}, TYPICAL_B, TYPICAL_C, 2'd1);
      random_readings(100, 2'd1);
      wait_idle();

      // zero temperature divisor: ac5 and md both zero
      write_cal(TYPICAL_A, {16'd0, TYPICAL_B[47:0]}, {TYPICAL_C[47:16], 16'd0}, 2'd2);
      random_readings(80, 2'd2);
      wait_idle();

      // fully random calibrations
      repeat (3) begin
         ra = {$urandom, $urandom};
         rb = {$urandom, $urandom};
         rc = {16'($urandom), $urandom};
         ro = 2'($urandom);
         write_cal(ra, rb, rc, ro);
         random_readings(110, ro);
         wait_idle();
      end

      // typical part with small random perturbation, no idling at all
      ro = 2'($urandom);
      write_cal(TYPICAL_A ^ 64'($urandom_range(0, 255)), TYPICAL_B, TYPICAL_C, ro);
      calm = 1'b1;
      random_readings(150, ro);
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/barometric_pressure_compensation_core.sv
tb/bpc_tb_pkg.sv
tb/pressure_checker.sv
tb/testbench.sv
